@@ src/sprq_pkg.sv @@
// ----------------------------------------------------------------------------
// sprq_pkg - shared types and constants for the stable priority ready queue
// Entry layout, opcodes, status codes, sequencer states and key saturation.
// ----------------------------------------------------------------------------
package sprq_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_BITS = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int ID_W     = 8;
    localparam int SEQ_W    = 16;
    localparam int IN_KEY_W = 16;
    localparam int OCC_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // key limits, held at 33 bits so any KEY_BITS up to 32 fits
    localparam logic signed [32:0] KEY_MAX_W = (33'sd1 <<< (KEY_BITS - 1)) - 33'sd1;
    localparam logic signed [32:0] KEY_MIN_W = -KEY_MAX_W - 33'sd1;
    localparam logic signed [32:0] OUT_MAX_W = 33'sd32767;
    localparam logic signed [32:0] OUT_MIN_W = -33'sd32768;
    localparam logic [KEY_BITS-1:0] KEY_MIN  = {1'b1, {(KEY_BITS - 1){1'b0}}};

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ORDER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AGE_THR    = 2'd1;
    localparam logic [7:0]           AGE_THR_RESET  = 8'd10;

    // order modes (3 falls back to least key first)
    localparam logic [1:0] MODE_LEAST    = 2'd0;
    localparam logic [1:0] MODE_GREATEST = 2'd1;
    localparam logic [1:0] MODE_ARRIVAL  = 2'd2;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_AGE    = 2'd2,
        OP_TICK   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]            id;
        logic signed [KEY_BITS-1:0] key;
        logic [SEQ_W-1:0]           seq;
    } t_entry;

    // input key saturated to the stored key range
    function automatic logic [KEY_BITS-1:0] sat_in_key(input logic [IN_KEY_W-1:0] k);
        logic signed [32:0] w;
        w = {{(33 - IN_KEY_W){k[IN_KEY_W-1]}}, k};
        if (w > KEY_MAX_W)      w = KEY_MAX_W;
        else if (w < KEY_MIN_W) w = KEY_MIN_W;
        return w[KEY_BITS-1:0];
    endfunction

    // stored key saturated to the 16 bit result range
    function automatic logic [IN_KEY_W-1:0] sat_out_key(input logic [KEY_BITS-1:0] k);
        logic signed [32:0] w;
        w = {{(33 - KEY_BITS){k[KEY_BITS-1]}}, k};
        if (w > OUT_MAX_W)      w = OUT_MAX_W;
        else if (w < OUT_MIN_W) w = OUT_MIN_W;
        return w[IN_KEY_W-1:0];
    endfunction

endpackage

@@ src/sprq_cmp.sv @@
// ----------------------------------------------------------------------------
// sprq_cmp - shared ordering comparator and saturating key decrement
// Decides whether the candidate entry leaves before the current best.
// ----------------------------------------------------------------------------
module sprq_cmp (
    input  sprq_pkg::t_entry             i_cand,
    input  sprq_pkg::t_entry             i_best,
    input  logic [1:0]                   i_mode,
    output logic                         o_first,
    output logic [sprq_pkg::KEY_BITS-1:0] o_dec_key
);

    logic key_ne;
    logic key_lt;
    logic seq_lt;

    assign key_ne = (i_cand.key != i_best.key);
    assign key_lt = ($signed(i_cand.key) < $signed(i_best.key));
    assign seq_lt = (i_cand.seq < i_best.seq);

    always_comb begin
        case (i_mode)
            sprq_pkg::MODE_GREATEST: o_first = key_ne ? !key_lt : seq_lt;
            sprq_pkg::MODE_ARRIVAL:  o_first = seq_lt;
            default:                 o_first = key_ne ? key_lt : seq_lt;
        endcase
    end

    // decrement saturates at the most negative key
    assign o_dec_key = (i_cand.key == sprq_pkg::KEY_MIN) ? i_cand.key
                                                         : i_cand.key - 1'b1;

endmodule

@@ src/stable_priority_ready_queue.sv @@
// ----------------------------------------------------------------------------
// stable_priority_ready_queue - stable min/max priority ready queue with aging
// Insert, pop best, age and tick over a small slot store, using one shared
// comparator/decrement unit stepped through the slots by a sequencer.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake           payload
//  -------   ---------  ------------------  ------------------------------------
//  input     in         i_valid / o_ready   i_opcode i_proc_id i_key_value i_now
//  result    out        o_valid / i_ready   o_status o_out_id o_out_key o_out_seq
//                                           o_occupancy
//  config    in         i_cfg_we            i_cfg_idx i_cfg_data
//
//  Sequence: insert and empty-queue ops go straight to the finish state; age,
//  tick and pop first scan the N held entries, and pop then moves the last
//  entry into the freed slot. The scan reads one slot per cycle through the
//  single store read port, feeding the one shared comparator.
//  Reset: synchronous, active low; clears fill count, sequence counter,
//  config and control state. Slot contents are not cleared.
//  Stalls: a finished result waits in the output register; the sequencer
//  holds in its finish state until that register is free.
//
module stable_priority_ready_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [1:0]                          i_opcode,
    input  logic [sprq_pkg::ID_W-1:0]           i_proc_id,
    input  logic signed [sprq_pkg::IN_KEY_W-1:0] i_key_value,
    input  logic [sprq_pkg::SEQ_W-1:0]          i_now,
    // result channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [1:0]                          o_status,
    output logic [sprq_pkg::ID_W-1:0]           o_out_id,
    output logic signed [sprq_pkg::IN_KEY_W-1:0] o_out_key,
    output logic [sprq_pkg::SEQ_W-1:0]          o_out_seq,
    output logic [sprq_pkg::OCC_W-1:0]          o_occupancy,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [sprq_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [sprq_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int IDX_W = sprq_pkg::IDX_W;
    localparam int CNT_W = sprq_pkg::CNT_W;

    // ---------------------------------------------------------------- state
    sprq_pkg::t_state  r_state, n_state;

    logic [1:0]        r_order_mode;
    logic [7:0]        r_age_thr;

    logic [CNT_W-1:0]  r_fill;
    logic [sprq_pkg::SEQ_W-1:0] r_next_seq;

    // latched operation
    sprq_pkg::t_opcode r_op;
    logic [sprq_pkg::ID_W-1:0]     r_pid;
    logic [sprq_pkg::KEY_BITS-1:0] r_kin;
    logic [sprq_pkg::SEQ_W-1:0]    r_limit;
    logic              r_age_en;
    logic [1:0]        r_status;

    // scan control: issue counter and one read in flight
    logic [CNT_W-1:0]  r_cnt;
    logic              r_pend;
    logic [IDX_W-1:0]  r_pidx;

    // best-so-far for pop
    sprq_pkg::t_entry  r_best;
    logic [IDX_W-1:0]  r_best_idx;

    // slot store, one write and one registered read port
    sprq_pkg::t_entry  r_mem [sprq_pkg::CAPACITY];
    sprq_pkg::t_entry  r_mem_q;

    // output register
    logic              r_ovalid;
    logic [1:0]        r_ostatus;
    logic [sprq_pkg::ID_W-1:0]     r_oid;
    logic [sprq_pkg::IN_KEY_W-1:0] r_okey;
    logic [sprq_pkg::SEQ_W-1:0]    r_oseq;
    logic [sprq_pkg::OCC_W-1:0]    r_oocc;

    // ---------------------------------------------------------------- comb
    logic              in_fire;
    logic              out_free;
    logic              scan_done;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_wa;
    sprq_pkg::t_entry  mem_wd;
    logic [IDX_W-1:0]  mem_ra;
    logic              cmp_first;
    logic [sprq_pkg::KEY_BITS-1:0] cmp_dec_key;
    logic              age_hit;
    logic [CNT_W-1:0]  last_cnt;
    logic [CNT_W-1:0]  fill_after;

    assign in_fire   = i_valid && o_ready;
    assign out_free  = !r_ovalid || i_ready;
    assign scan_done = (r_cnt == r_fill) && !r_pend;
    assign last_cnt  = r_fill - 1'b1;
    assign age_hit   = (r_op == sprq_pkg::OP_TICK) ||
                       (r_age_en && (r_mem_q.seq < r_limit));

    sprq_cmp u_cmp (
        .i_cand    (r_mem_q),
        .i_best    (r_best),
        .i_mode    (r_order_mode),
        .o_first   (cmp_first),
        .o_dec_key (cmp_dec_key)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sprq_pkg::S_IDLE: begin
                if (i_valid) begin
                    if (sprq_pkg::t_opcode'(i_opcode) == sprq_pkg::OP_INSERT || r_fill == '0)
                        n_state = sprq_pkg::S_FINISH;
                    else
                        n_state = sprq_pkg::S_SCAN;
                end
            end
            sprq_pkg::S_SCAN: begin
                if (scan_done)
                    n_state = (r_op == sprq_pkg::OP_POP) ? sprq_pkg::S_MOVE_RD
                                                         : sprq_pkg::S_FINISH;
            end
            sprq_pkg::S_MOVE_RD: n_state = sprq_pkg::S_MOVE_WR;
            sprq_pkg::S_MOVE_WR: n_state = sprq_pkg::S_FINISH;
            sprq_pkg::S_FINISH: begin
                if (out_free)
                    n_state = sprq_pkg::S_IDLE;
            end
            default: n_state = sprq_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs: handshake and store port control
    always_comb begin
        o_ready = 1'b0;
        mem_we  = 1'b0;
        mem_wa  = r_pidx;
        mem_wd  = r_mem_q;
        mem_ra  = r_cnt[IDX_W-1:0];
        unique case (r_state)
            sprq_pkg::S_IDLE: o_ready = 1'b1;
            sprq_pkg::S_SCAN: begin
                // age/tick write back the slot read in the previous cycle
                if (r_pend && r_op != sprq_pkg::OP_POP && age_hit) begin
                    mem_we     = 1'b1;
                    mem_wd.key = cmp_dec_key;
                end
            end
            sprq_pkg::S_MOVE_RD: mem_ra = last_cnt[IDX_W-1:0];
            sprq_pkg::S_MOVE_WR: begin
                // last entry fills the hole left by the popped one
                mem_we = 1'b1;
                mem_wa = r_best_idx;
            end
            sprq_pkg::S_FINISH: begin
                if (out_free && r_op == sprq_pkg::OP_INSERT && r_status == sprq_pkg::ST_OK) begin
                    mem_we = 1'b1;
                    mem_wa = r_fill[IDX_W-1:0];
                    mem_wd = '{id: r_pid, key: r_kin, seq: r_next_seq};
                end
            end
            default: ;
        endcase
    end

    assign fill_after = (r_op == sprq_pkg::OP_INSERT && r_status == sprq_pkg::ST_OK)
                        ? r_fill + 1'b1 : r_fill;

    // ---------------------------------------------------------------- store
    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[mem_wa] <= mem_wd;
        r_mem_q <= r_mem[mem_ra];
    end

    // ---------------------------------------------------------------- control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sprq_pkg::S_IDLE;
            r_order_mode <= sprq_pkg::MODE_LEAST;
            r_age_thr    <= sprq_pkg::AGE_THR_RESET;
            r_fill       <= '0;
            r_next_seq   <= '0;
            r_cnt        <= '0;
            r_pend       <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    sprq_pkg::CFG_ORDER_MODE: r_order_mode <= i_cfg_data[1:0];
                    sprq_pkg::CFG_AGE_THR:    r_age_thr    <= i_cfg_data;
                    default: ;
                endcase
            end

            if (in_fire) begin
                r_cnt  <= '0;
                r_pend <= 1'b0;
            end else if (r_state == sprq_pkg::S_SCAN) begin
                r_pend <= (r_cnt < r_fill);
                if (r_cnt < r_fill)
                    r_cnt <= r_cnt + 1'b1;
            end

            if (r_state == sprq_pkg::S_MOVE_WR)
                r_fill <= r_fill - 1'b1;

            if (r_state == sprq_pkg::S_FINISH && out_free) begin
                r_ovalid <= 1'b1;
                r_fill   <= fill_after;
                if (r_op == sprq_pkg::OP_INSERT && r_status == sprq_pkg::ST_OK)
                    r_next_seq <= r_next_seq + 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- payload
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op     <= sprq_pkg::t_opcode'(i_opcode);
            r_pid    <= i_proc_id;
            r_kin    <= sprq_pkg::sat_in_key(i_key_value);
            r_age_en <= ({8'd0, r_age_thr} <= i_now);
            r_limit  <= i_now - {8'd0, r_age_thr};
            if (sprq_pkg::t_opcode'(i_opcode) == sprq_pkg::OP_INSERT && r_fill >= sprq_pkg::CAP_CNT)
                r_status <= sprq_pkg::ST_FULL;
            else if (sprq_pkg::t_opcode'(i_opcode) == sprq_pkg::OP_POP && r_fill == '0)
                r_status <= sprq_pkg::ST_EMPTY;
            else
                r_status <= sprq_pkg::ST_OK;
        end

        if (r_state == sprq_pkg::S_SCAN)
            r_pidx <= r_cnt[IDX_W-1:0];

        // first slot seeds the best; later slots replace it only when strictly ahead
        if (r_state == sprq_pkg::S_SCAN && r_pend && r_op == sprq_pkg::OP_POP) begin
            if (r_pidx == '0 || cmp_first) begin
                r_best     <= r_mem_q;
                r_best_idx <= r_pidx;
            end
        end

        if (r_state == sprq_pkg::S_FINISH && out_free) begin
            r_ostatus <= r_status;
            r_oocc    <= sprq_pkg::OCC_W'(fill_after);
            r_oid     <= '0;
            r_okey    <= '0;
            r_oseq    <= '0;
            if (r_status == sprq_pkg::ST_OK) begin
                if (r_op == sprq_pkg::OP_INSERT) begin
                    r_oseq <= r_next_seq;
                end else if (r_op == sprq_pkg::OP_POP) begin
                    r_oid  <= r_best.id;
                    r_okey <= sprq_pkg::sat_out_key(r_best.key);
                    r_oseq <= r_best.seq;
                end
            end
        end
    end

    assign o_valid     = r_ovalid;
    assign o_status    = r_ostatus;
    assign o_out_id    = r_oid;
    assign o_out_key   = r_okey;
    assign o_out_seq   = r_oseq;
    assign o_occupancy = r_oocc;

    // ---------------------------------------------------------------- checks
    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= sprq_pkg::CAP_CNT)
        else $error("fill count beyond capacity");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sprq_pkg::S_SCAN) |-> (r_cnt <= r_fill))
        else $error("scan ran past the held entries");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state != sprq_pkg::S_IDLE))
        else $error("slot store written while idle");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sprq_pkg::S_MOVE_WR) |=> (r_fill == $past(r_fill) - 1'b1))
        else $error("pop did not remove one entry");

endmodule

@@ sim/stable_priority_ready_queue_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_ready_queue_test - self-checking bench for the ready queue
// Offers insert, pop, age and tick transfers with random gaps on both
// channels, works out each result from a shadow copy of the queue and
// compares every returned field against it, across several register settings.
// ----------------------------------------------------------------------------
module stable_priority_ready_queue_test;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 40;       // margin beyond the slowest pop
    localparam int HOLD_CYCLES   = 300;      // receiver hold-off, fills the block
    localparam int REPORT_LIMIT  = 10;
    localparam int IDLE_PCT      = 30;
    localparam int PHASE_ITEMS   = 270;
    localparam int RUN_LIMIT_NS  = 20_000_000;

    // order mode 3 is not defined and must behave as least key first
    localparam logic [1:0]                     MODE_SPARE  = 2'd3;
    // register indexes the block does not decode
    localparam logic [sprq_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [sprq_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [sprq_pkg::IN_KEY_W-1:0]  KEY_TOP    = ~sprq_pkg::KEY_MIN;
    localparam logic [sprq_pkg::IN_KEY_W-1:0]  KEY_FLOOR  = sprq_pkg::KEY_MIN;

    typedef struct packed {
        sprq_pkg::t_opcode                 op;
        logic [sprq_pkg::ID_W-1:0]         pid;
        logic [sprq_pkg::IN_KEY_W-1:0]     key;
        logic [sprq_pkg::SEQ_W-1:0]        now;
    } t_request;

    typedef struct packed {
        logic [1:0]                        status;
        logic [sprq_pkg::ID_W-1:0]         id;
        logic [sprq_pkg::IN_KEY_W-1:0]     key;
        logic [sprq_pkg::SEQ_W-1:0]        seq;
        logic [sprq_pkg::OCC_W-1:0]        occ;
    } t_result;

    // ------------------------------------------------------------------------
    // Block ports; every input holds a known value from time zero
    // ------------------------------------------------------------------------
    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_valid     = 1'b0;
    logic                               o_ready;
    logic [1:0]                         i_opcode    = sprq_pkg::OP_INSERT;
    logic [sprq_pkg::ID_W-1:0]          i_proc_id   = '0;
    logic [sprq_pkg::IN_KEY_W-1:0]      i_key_value = '0;
    logic [sprq_pkg::SEQ_W-1:0]         i_now       = '0;
    logic                               o_valid;
    logic                               i_ready     = 1'b0;
    logic [1:0]                         o_status;
    logic [sprq_pkg::ID_W-1:0]          o_out_id;
    logic [sprq_pkg::IN_KEY_W-1:0]      o_out_key;
    logic [sprq_pkg::SEQ_W-1:0]         o_out_seq;
    logic [sprq_pkg::OCC_W-1:0]         o_occupancy;
    logic                               i_cfg_we    = 1'b0;
    logic [sprq_pkg::CFG_IDX_W-1:0]     i_cfg_idx   = sprq_pkg::CFG_ORDER_MODE;
    logic [sprq_pkg::CFG_DATA_W-1:0]    i_cfg_data  = '0;

    stable_priority_ready_queue i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_opcode    (i_opcode),
        .i_proc_id   (i_proc_id),
        .i_key_value (i_key_value),
        .i_now       (i_now),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_status    (o_status),
        .o_out_id    (o_out_id),
        .o_out_key   (o_out_key),
        .o_out_seq   (o_out_seq),
        .o_occupancy (o_occupancy),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_request backlog[$];        // items waiting to be offered
    t_result  due_results[$];    // results owed by the block, oldest first
    int       queued_cnt   = 0;
    int       accepted_cnt = 0;
    int       fault_cnt    = 0;
    logic     in_fire      = 1'b0;   // input transfer at the last rising edge
    int       idle_pct     = IDLE_PCT;
    bit       hold_req     = 1'b0;
    int       hold_left    = 0;

    // generator-side tracking of fill and stamp; exact, as both follow from
    // the opcode sequence alone
    int                         gen_fill = 0;
    logic [sprq_pkg::SEQ_W-1:0] gen_seq  = '0;

    // shadow copy of the queue, updated once per accepted input transfer
    logic [sprq_pkg::ID_W-1:0]            shadow_id  [sprq_pkg::CAPACITY];
    logic signed [sprq_pkg::KEY_BITS-1:0] shadow_key [sprq_pkg::CAPACITY];
    logic [sprq_pkg::SEQ_W-1:0]           shadow_seq [sprq_pkg::CAPACITY];
    int                                   shadow_fill     = 0;
    logic [sprq_pkg::SEQ_W-1:0]           shadow_next_seq = '0;
    logic [1:0]                           shadow_mode     = sprq_pkg::MODE_LEAST;
    logic [7:0]                           shadow_thr      = sprq_pkg::AGE_THR_RESET;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // true when slot a leaves before slot b; equal keys fall back to the stamp
    function automatic bit leaves_first(input int a, input int b);
        if (shadow_mode == sprq_pkg::MODE_GREATEST) begin
            if (shadow_key[a] != shadow_key[b]) return shadow_key[a] > shadow_key[b];
        end else if (shadow_mode != sprq_pkg::MODE_ARRIVAL) begin
            if (shadow_key[a] != shadow_key[b]) return shadow_key[a] < shadow_key[b];
        end
        return shadow_seq[a] < shadow_seq[b];
    endfunction

    // decrement that sticks at the most negative key
    function automatic logic signed [sprq_pkg::KEY_BITS-1:0] key_less_one(
        input logic signed [sprq_pkg::KEY_BITS-1:0] k);
        return (k == $signed(sprq_pkg::KEY_MIN)) ? k
                                                 : k - $signed(sprq_pkg::KEY_BITS'(1));
    endfunction

    // applies one operation to the shadow queue and returns the block's answer;
    // stored and reported keys are both 16 bits wide, so no saturation applies
    function automatic t_result queue_response(input t_request req);
        t_result r;
        int      best;
        int      limit;
        r = '0;
        case (req.op)
            sprq_pkg::OP_INSERT: begin
                if (shadow_fill >= sprq_pkg::CAPACITY) begin
                    r.status = sprq_pkg::ST_FULL;
                end else begin
                    shadow_id[shadow_fill]  = req.pid;
                    shadow_key[shadow_fill] = req.key;
                    shadow_seq[shadow_fill] = shadow_next_seq;
                    r.seq                   = shadow_next_seq;
                    shadow_next_seq         = shadow_next_seq + 1'b1;
                    shadow_fill++;
                end
            end
            sprq_pkg::OP_POP: begin
                if (shadow_fill == 0) begin
                    r.status = sprq_pkg::ST_EMPTY;
                end else begin
                    best = 0;
                    for (int i = 1; i < shadow_fill; i++)
                        if (leaves_first(i, best)) best = i;
                    r.id  = shadow_id[best];
                    r.key = shadow_key[best];
                    r.seq = shadow_seq[best];
                    // the last entry moves into the freed slot
                    shadow_fill--;
                    shadow_id[best]  = shadow_id[shadow_fill];
                    shadow_key[best] = shadow_key[shadow_fill];
                    shadow_seq[best] = shadow_seq[shadow_fill];
                end
            end
            sprq_pkg::OP_AGE: begin
                // nothing qualifies while now is below the threshold
                if (req.now >= shadow_thr) begin
                    limit = int'(req.now) - int'(shadow_thr);
                    for (int i = 0; i < shadow_fill; i++)
                        if (int'(shadow_seq[i]) < limit)
                            shadow_key[i] = key_less_one(shadow_key[i]);
                end
            end
            default: begin
                for (int i = 0; i < shadow_fill; i++)
                    shadow_key[i] = key_less_one(shadow_key[i]);
            end
        endcase
        r.occ = sprq_pkg::OCC_W'(shadow_fill);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: checks result transfers, predicts on input transfers
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result  got;
        t_result  want;
        t_request req;
        if (!i_rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= i_valid && o_ready;
            if (o_valid && i_ready) begin
                got.status = o_status;
                got.id     = o_out_id;
                got.key    = o_out_key;
                got.seq    = o_out_seq;
                got.occ    = o_occupancy;
                if (due_results.size() == 0) begin
                    fault_cnt++;
                    if (fault_cnt <= REPORT_LIMIT)
                        $display("%0t: result with none owed: st=%0d id=%0d key=%0d seq=%0d occ=%0d",
                                 $realtime, got.status, got.id, $signed(got.key), got.seq,
                                 got.occ);
                end else begin
                    want = due_results.pop_front();
                    if (got.status !== want.status || got.id !== want.id ||
                        got.key !== want.key || got.seq !== want.seq ||
                        got.occ !== want.occ) begin
                        fault_cnt++;
                        if (fault_cnt <= REPORT_LIMIT)
                            $display("%0t: mismatch exp st=%0d id=%0d key=%0d seq=%0d occ=%0d | got st=%0d id=%0d key=%0d seq=%0d occ=%0d",
                                     $realtime, want.status, want.id, $signed(want.key),
                                     want.seq, want.occ, got.status, got.id,
                                     $signed(got.key), got.seq, got.occ);
                    end
                end
            end
            if (i_valid && o_ready) begin
                req.op  = sprq_pkg::t_opcode'(i_opcode);
                req.pid = i_proc_id;
                req.key = i_key_value;
                req.now = i_now;
                due_results.push_back(queue_response(req));
                accepted_cnt++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driver: presents the next item once the previous one has transferred
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        t_request nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fire) begin
            if (backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                nxt          = backlog.pop_front();
                i_valid     <= 1'b1;
                i_opcode    <= nxt.op;
                i_proc_id   <= nxt.pid;
                i_key_value <= nxt.key;
                i_now       <= nxt.now;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic offer(input sprq_pkg::t_opcode op,
                         input logic [sprq_pkg::ID_W-1:0] pid,
                         input logic [sprq_pkg::IN_KEY_W-1:0] key,
                         input logic [sprq_pkg::SEQ_W-1:0] now);
        t_request req;
        req.op  = op;
        req.pid = pid;
        req.key = key;
        req.now = now;
        backlog.push_back(req);
        queued_cnt++;
        if (op == sprq_pkg::OP_INSERT && gen_fill < sprq_pkg::CAPACITY) begin
            gen_fill++;
            gen_seq++;
        end else if (op == sprq_pkg::OP_POP && gen_fill > 0) begin
            gen_fill--;
        end
    endtask

    // extremes, the area near the floor, a narrow band for ties, or anything
    function automatic logic [sprq_pkg::IN_KEY_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0:       return KEY_TOP;
            1:       return KEY_FLOOR;
            2:       return KEY_FLOOR + sprq_pkg::IN_KEY_W'($urandom_range(0, 3));
            3, 4, 5: return sprq_pkg::IN_KEY_W'($urandom_range(0, 8) - 4);
            default: return sprq_pkg::IN_KEY_W'($urandom);
        endcase
    endfunction

    // mostly times near the current stamp so that aging splits the queue
    function automatic logic [sprq_pkg::SEQ_W-1:0] pick_now();
        case ($urandom_range(0, 7))
            0:       return sprq_pkg::SEQ_W'($urandom);
            1:       return '1;
            2:       return sprq_pkg::SEQ_W'($urandom_range(0, 15));
            3, 4:    return sprq_pkg::SEQ_W'(int'(gen_seq) + int'(shadow_thr) +
                                             $urandom_range(0, 16) - 8);
            default: return sprq_pkg::SEQ_W'(int'(gen_seq) + $urandom_range(0, 300));
        endcase
    endfunction

    // random traffic in stretches that lean towards filling, emptying or neither
    task automatic offer_mix(input int n_items);
        int                lean;
        int                roll;
        int                ins_pct;
        sprq_pkg::t_opcode op;
        lean = 0;
        for (int k = 0; k < n_items; k++) begin
            if (k % 48 == 0) lean = $urandom_range(0, 2);
            ins_pct = (lean == 0) ? 65 : (lean == 1) ? 10 : 38;
            roll = $urandom_range(0, 99);
            if (roll < 15)                op = sprq_pkg::OP_AGE;
            else if (roll < 25)           op = sprq_pkg::OP_TICK;
            else if (roll < 25 + ins_pct) op = sprq_pkg::OP_INSERT;
            else                          op = sprq_pkg::OP_POP;
            offer(op, sprq_pkg::ID_W'($urandom_range(0, 255)), pick_key(), pick_now());
        end
    endtask

    // waits until every offered item has transferred and been answered
    task automatic wait_drained();
        while (accepted_cnt != queued_cnt || due_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sprq_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sprq_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == sprq_pkg::CFG_ORDER_MODE)   shadow_mode = data[1:0];
        else if (idx == sprq_pkg::CFG_AGE_THR) shadow_thr  = data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // drain, then set both registers; upper bits of the mode write are junk
    task automatic next_phase(input logic [1:0] mode, input logic [7:0] thr,
                              input int idle);
        wait_drained();
        write_reg(sprq_pkg::CFG_ORDER_MODE, {6'($urandom), mode});
        write_reg(sprq_pkg::CFG_AGE_THR, thr);
        @(posedge i_clk);
        idle_pct = idle;
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset settings: least key first, threshold 10
        offer(sprq_pkg::OP_POP,  8'h00, '0, '0);          // pop on an empty queue
        offer(sprq_pkg::OP_AGE,  8'h00, '0, '1);          // age and tick, nothing held
        offer(sprq_pkg::OP_TICK, 8'h00, '0, '0);
        offer(sprq_pkg::OP_INSERT, 8'hff, KEY_TOP,   '0);
        offer(sprq_pkg::OP_INSERT, 8'h00, KEY_FLOOR, '0);
        offer(sprq_pkg::OP_INSERT, 8'h5a, 16'd5, '0);     // equal keys: older first
        offer(sprq_pkg::OP_INSERT, 8'ha5, 16'd5, '0);
        offer(sprq_pkg::OP_TICK, 8'h00, '0, '0);          // floor key stays put
        offer(sprq_pkg::OP_AGE,  8'h00, '0, 16'd9);       // now below threshold
        offer(sprq_pkg::OP_AGE,  8'h00, '0, 16'd12);      // only stamps 0 and 1
        for (int k = 0; k < sprq_pkg::CAPACITY - 4; k++)
            offer(sprq_pkg::OP_INSERT, sprq_pkg::ID_W'(k), pick_key(), '0);
        offer(sprq_pkg::OP_INSERT, 8'h77, 16'd1, '0);     // full: dropped, no stamp
        offer(sprq_pkg::OP_AGE,  8'h00, '0, '1);
        offer(sprq_pkg::OP_POP,  8'h00, '0, '0);
        offer(sprq_pkg::OP_POP,  8'h00, '0, '0);
        offer(sprq_pkg::OP_POP,  8'h00, '0, '0);

        // greatest key first, threshold zero so stamps below now age; long receiver hold-off while
        // the sender keeps offering, so the block backs up and stalls
        next_phase(sprq_pkg::MODE_GREATEST, 8'd0, IDLE_PCT);
        offer_mix(PHASE_ITEMS);
        @(posedge i_clk);
        hold_req = 1'b1;

        next_phase(sprq_pkg::MODE_ARRIVAL, 8'd255, IDLE_PCT);
        offer_mix(PHASE_ITEMS);

        // undefined mode, and writes to indexes the block must ignore
        next_phase(MODE_SPARE, 8'($urandom), IDLE_PCT);
        write_reg(CFG_SPARE_A, 8'($urandom));
        write_reg(CFG_SPARE_B, 8'($urandom));
        offer_mix(PHASE_ITEMS);

        // a stretch with no idling on either side
        next_phase(sprq_pkg::MODE_LEAST, 8'd255, 0);
        offer_mix(PHASE_ITEMS);

        next_phase(sprq_pkg::MODE_GREATEST, 8'($urandom), IDLE_PCT);
        offer_mix(PHASE_ITEMS);

        // empty the queue, then refill it with fresh stamps in arrival order
        next_phase(sprq_pkg::MODE_ARRIVAL, sprq_pkg::AGE_THR_RESET, 0);
        for (int k = 0; k < sprq_pkg::CAPACITY; k++)
            offer(sprq_pkg::OP_POP, 8'h00, '0, '0);
        for (int k = 0; k < 5; k++)
            offer(sprq_pkg::OP_INSERT, sprq_pkg::ID_W'($urandom_range(0, 255)),
                  pick_key(), '0);
        offer_mix(200);
        next_phase(sprq_pkg::MODE_LEAST, 8'd255, IDLE_PCT);
        offer_mix(200);

        wait_drained();
        if (fault_cnt == 0 && due_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // hard limit on the run
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
